### sv/mbps_pkg.sv
// Package of shared types and constants for the masked byte pattern scan.
`default_nettype none

package mbps_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int OFFSET_BITS = 32;
  localparam int IDX_W = $clog2(MAX_PATTERN);
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int MASK_W = MAX_PATTERN;
  localparam int CFG_DATA_W = MASK_W;
  localparam int CFG_INDEX_W = 1;

  typedef logic [7:0] byte_t;
  typedef logic [IDX_W-1:0] pat_idx_t;
  typedef logic [LEN_W-1:0] pat_len_t;
  typedef logic [OFFSET_BITS-1:0] pos_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_SCAN = 1'b1
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COMPARE_MASK   = 1'b0,
    REG_PATTERN_LENGTH = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic        found;
    logic [31:0] match_offset;
  } result_t;

endpackage

`default_nettype wire

### sv/mbps_in_if.sv
// Input channel of the scan: pattern loads and buffer bytes.
`default_nettype none

interface mbps_in_if import mbps_pkg::*; ();
  logic     valid;
  logic     ready;
  logic     operation;
  pat_idx_t pattern_index;
  byte_t    data_byte;
  logic     end_of_buffer;

  modport source(output valid, operation, pattern_index, data_byte, end_of_buffer,
                 input ready);
  modport sink(input valid, operation, pattern_index, data_byte, end_of_buffer,
               output ready);
endinterface

`default_nettype wire

### sv/mbps_out_if.sv
// Result channel of the scan: found flag and match offset.
`default_nettype none

interface mbps_out_if import mbps_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] match_offset;

  modport source(output valid, found, match_offset, input ready);
  modport sink(input valid, found, match_offset, output ready);
endinterface

`default_nettype wire

### sv/mbps_cell.sv
// One window cell: holds one buffer byte, passes it on and compares the byte it takes in.
`default_nettype none

module mbps_cell import mbps_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  cell_ctrl_t ctrl,
  input  byte_t      byte_in,
  input  byte_t      pat_byte,
  input  wire        must,
  input  wire        active,
  output byte_t      byte_out,
  output logic       hit
);

  byte_t win_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_byte <= '0;
    end else if (ctrl.shift) begin
      win_byte <= ctrl.clear ? byte_t'(0) : byte_in;
    end
  end

  // The compare sees the byte this cell takes in on the current transfer.
  assign hit = !active || !must || (byte_in == pat_byte);
  assign byte_out = win_byte;

endmodule

`default_nettype wire

### sv/mbps_align.sv
// Pattern store with a shifter that lines pattern bytes up with window cells.
`default_nettype none

module mbps_align import mbps_pkg::*; (
  input  wire      clk,
  input  wire      load,
  input  pat_idx_t load_index,
  input  byte_t    load_byte,
  input  pat_len_t len_eff,
  output byte_t    aligned [MAX_PATTERN]
);

  localparam int STAGES = IDX_W;

  byte_t    pat [MAX_PATTERN];
  byte_t    stage [STAGES+1][MAX_PATTERN];
  pat_idx_t sh;

  always_ff @(posedge clk) begin
    if (load) begin
      pat[load_index] <= load_byte;
    end
  end

  // Cell k needs pattern byte len-1-k: reverse the store, shift by MAX_PATTERN-len.
  always_comb begin
    sh = pat_idx_t'(LEN_W'(MAX_PATTERN) - len_eff);
    for (int j = 0; j < MAX_PATTERN; j++) begin
      stage[0][j] = pat[MAX_PATTERN-1-j];
    end
    for (int s = 0; s < STAGES; s++) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        if (!sh[s]) begin
          stage[s+1][j] = stage[s][j];
        end else if (j + (1 << s) < MAX_PATTERN) begin
          stage[s+1][j] = stage[s][j + (1 << s)];
        end else begin
          stage[s+1][j] = '0;
        end
      end
    end
    for (int j = 0; j < MAX_PATTERN; j++) begin
      aligned[j] = stage[STAGES][j];
    end
  end

endmodule

`default_nettype wire

### sv/mbps_res_fifo.sv
// Two-entry result queue that drives the result channel.
`default_nettype none

module mbps_res_fifo import mbps_pkg::*; (
  input  wire     clk,
  input  wire     rst,
  input  wire     push,
  input  result_t push_data,
  output logic    full,
  mbps_out_if.source result
);

  result_t    entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop = result.valid && result.ready;
  assign full = (count == 2'd2);
  assign result.valid = (count != 2'd0);
  assign result.found = entry[rd_ptr].found;
  assign result.match_offset = entry[rd_ptr].match_offset;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push || pop) else $error("result queue overflow");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("result queue count out of range");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 && !push) |=> count == 2'd0) else $error("result queue underflow");

endmodule

`default_nettype wire

### sv/masked_byte_pattern_scan_top.sv
// Top level of the masked byte pattern scan: window cell row, pattern store, result queue.
//
//   channel  | direction | payload                                          | transfer
//   scan     | in        | operation, pattern_index, data_byte, end_of_buffer | valid & ready
//   result   | out       | found, match_offset                              | valid & ready
//   cfg      | in        | cfg_index, cfg_data                              | cfg_write
//
// One item per cycle while scan ready is high; a scan result is registered in the result queue.
// The compare of all 64 window cells against the aligned pattern happens in the transfer cycle.
// A two-entry result queue keeps scan ready while one result waits; ready drops only when both
// entries are full. Reset is synchronous and clears the window, position and match flag.
`default_nettype none

module masked_byte_pattern_scan_top import mbps_pkg::*; (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cfg_write,
  input  wire [CFG_INDEX_W-1:0] cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_data,
  mbps_in_if.sink               scan,
  mbps_out_if.source            result
);

  logic [MASK_W-1:0] compare_mask;
  pat_len_t          pattern_length;
  pos_t              byte_position;
  logic              match_reported;

  pat_len_t   len_eff;
  pat_idx_t   len_m1;
  byte_t      aligned [MAX_PATTERN];
  byte_t      chain [MAX_PATTERN+1];
  logic [MAX_PATTERN-1:0] hits;
  cell_ctrl_t cell_ctrl;
  logic       full;
  logic       scan_acc;
  logic       load_acc;
  logic       cand;
  logic       match;
  logic       push;
  result_t    push_data;
  pos_t       byte_position_next;
  logic       match_reported_next;

  assign scan.ready = !full;
  assign scan_acc = scan.valid && scan.ready && (op_t'(scan.operation) == OP_SCAN);
  assign load_acc = scan.valid && scan.ready && (op_t'(scan.operation) == OP_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      compare_mask <= '1;
      pattern_length <= pat_len_t'(1);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COMPARE_MASK:   compare_mask <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pattern_length == '0) begin
      len_eff = pat_len_t'(1);
    end else if (pattern_length > pat_len_t'(MAX_PATTERN)) begin
      len_eff = pat_len_t'(MAX_PATTERN);
    end else begin
      len_eff = pattern_length;
    end
    len_m1 = pat_idx_t'(len_eff - pat_len_t'(1));
  end

  mbps_align u_align (
    .clk        (clk),
    .load       (load_acc),
    .load_index (scan.pattern_index),
    .load_byte  (scan.data_byte),
    .len_eff    (len_eff),
    .aligned    (aligned)
  );

  assign cell_ctrl.shift = scan_acc;
  assign cell_ctrl.clear = scan.end_of_buffer;
  assign chain[0] = scan.data_byte;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    mbps_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (cell_ctrl),
      .byte_in  (chain[k]),
      .pat_byte (aligned[k]),
      .must     (compare_mask[k] || (pat_idx_t'(k) == len_m1)),
      .active   (pat_idx_t'(k) <= len_m1),
      .byte_out (chain[k+1]),
      .hit      (hits[k])
    );
  end

  always_comb begin
    cand = !match_reported && (byte_position >= pos_t'(len_m1));
    match = scan_acc && cand && (&hits);
    push = match || (scan_acc && scan.end_of_buffer && !match_reported);
    push_data.found = match;
    push_data.match_offset = match ? 32'(byte_position - pos_t'(len_m1)) : 32'd0;
    byte_position_next = byte_position;
    match_reported_next = match_reported;
    if (scan_acc) begin
      if (scan.end_of_buffer) begin
        byte_position_next = '0;
        match_reported_next = 1'b0;
      end else begin
        byte_position_next = byte_position + pos_t'(1);
        match_reported_next = match_reported || match;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      match_reported <= 1'b0;
    end else begin
      byte_position <= byte_position_next;
      match_reported <= match_reported_next;
    end
  end

  mbps_res_fifo u_res_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .result    (result)
  );

  a_push_on_scan: assert property (@(posedge clk) disable iff (rst)
    push |-> scan_acc) else $error("result pushed without a scan transfer");

  a_eob_clears: assert property (@(posedge clk) disable iff (rst)
    (scan_acc && scan.end_of_buffer) |=> (byte_position == '0) && !match_reported)
    else $error("end of buffer did not clear the scan state");

  a_single_report: assert property (@(posedge clk) disable iff (rst)
    match_reported |-> !match) else $error("second match reported in one buffer");

  a_rose_with_match: assert property (@(posedge clk) disable iff (rst)
    $rose(match_reported) |-> $past(match)) else $error("match flag set without a match");

endmodule

`default_nettype wire
